### hw/rtl/rbi_pkg.sv
`default_nettype none
package rbi_pkg;

  // widest component the datapath is sized for
  localparam int COMP_MAX = 21;
  localparam int Q_BITS   = 16;

  // configuration port
  localparam int          APB_AW          = 3;
  localparam int          APB_DW          = 32;
  localparam logic [0:0]  REG_TIME_STEP   = 1'b0;
  localparam logic [15:0] TIME_STEP_RESET = 16'd1092;

  typedef logic signed [COMP_MAX-1:0] comp_t;
  typedef logic signed [Q_BITS-1:0]   quat_t;
  typedef logic signed [19:0]         rot_t;

  // round half up: floor((x + 2^(s-1)) / 2^s)
  function automatic logic signed [63:0] rnd(input logic signed [63:0] x,
                                            input int unsigned s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rbi_if.sv
`default_nettype none
interface rbi_body_if;
  logic        valid;
  logic        ready;
  logic [62:0] position;
  logic [62:0] velocity;
  logic [62:0] angular_velocity;
  logic [62:0] force_sum;
  logic [62:0] torque_sum;
  logic [63:0] orientation;
  logic [23:0] inverse_mass;
  logic [62:0] inertia_row_zero;
  logic [62:0] inertia_row_one;
  logic [62:0] inertia_row_two;

  modport source (output valid, position, velocity, angular_velocity, force_sum, torque_sum,
                  orientation, inverse_mass, inertia_row_zero, inertia_row_one,
                  inertia_row_two, input ready);
  modport sink (input valid, position, velocity, angular_velocity, force_sum, torque_sum,
                orientation, inverse_mass, inertia_row_zero, inertia_row_one,
                inertia_row_two, output ready);
endinterface

interface rbi_result_if;
  logic        valid;
  logic        ready;
  logic [62:0] new_position;
  logic [62:0] new_velocity;
  logic [62:0] new_angular_velocity;
  logic [63:0] new_orientation;
  logic        is_static;
  logic        saturated;

  modport source (output valid, new_position, new_velocity, new_angular_velocity,
                  new_orientation, is_static, saturated, input ready);
  modport sink (input valid, new_position, new_velocity, new_angular_velocity,
                new_orientation, is_static, saturated, output ready);
endinterface
`default_nettype wire

### hw/rtl/rigid_body_integrator.sv
`default_nettype none
// channel     | dir | handshake     | payload
// body_in     | in  | valid/ready   | one rigid body state
// result_out  | out | valid/ready   | stepped body state and flags
// apb         | in  | psel/penable  | time_step register
//
// One body enters per cycle while the output is not stalled; it passes through
// 33 register stages before its result is presented.
// The depth is set by the square root (ten stages, three steps each) and the
// normalising divider (five stages, three quotient bits each).
// Reset clears every stage valid bit and sets time_step to 1092.
// Stages advance independently: a stage loads whenever it is empty or the one
// after it moves, so bubbles close up while the output waits.
module rigid_body_integrator
  import rbi_pkg::*;
#(
  parameter int COMPONENT_BITS = 21
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  rbi_body_if.sink               body_in,
  rbi_result_if.source           result_out
);

  localparam int CB = COMPONENT_BITS;
  localparam int NS = 33;
  localparam logic signed [63:0] CHI = (64'sd1 <<< (CB - 1)) - 64'sd1;
  localparam logic signed [63:0] CLO = -CHI - 64'sd1;

  typedef struct {
    logic              stat;
    logic              flag;
    logic [62:0]       pin;
    logic [62:0]       vin;
    logic [62:0]       win;
    logic [63:0]       qin;
    comp_t             p [3];
    comp_t             v [3];
    comp_t             w [3];
    comp_t             t [3];
    comp_t             im_row [3][3];
    quat_t             q [4];
    logic signed [31:0] qxx, qyy, qzz, qxy, qxz, qyz, qwx, qwy, qwz;
    logic signed [45:0] fim [3];
    logic signed [39:0] fdlo [3];
    logic signed [39:0] fdhi [3];
    rot_t              r [3][3];
    comp_t             nv [3];
    comp_t             np [3];
    logic signed [40:0] at [3][3];
    logic signed [26:0] a [3];
    logic signed [37:0] nvdt [3];
    logic signed [47:0] ia [3][3];
    logic signed [36:0] b [3];
    logic signed [39:0] rblo [3][3];
    logic signed [39:0] rbhi [3][3];
    logic signed [41:0] c [3];
    logic signed [38:0] cdlo [3];
    logic signed [38:0] cdhi [3];
    comp_t             nw [3];
    logic signed [36:0] dp [4][3];
    logic signed [38:0] d [4];
    logic signed [37:0] ddlo [4];
    logic signed [37:0] ddhi [4];
    logic signed [27:0] qn [4];
    logic [55:0]       qsq [4];
    logic              nz;
    logic [59:0]       nrem;
    logic [59:0]       nres;
    logic [29:0]       dd;
    logic [43:0]       dr [4];
    logic [14:0]       quo [4];
    logic              neg [4];
    logic [62:0]       out_p;
    logic [62:0]       out_v;
    logic [62:0]       out_w;
    logic [63:0]       out_q;
  } item_t;

  logic [15:0]        time_step;
  logic signed [16:0] dts;
  item_t              st  [1:NS];
  item_t              nxt [1:NS];
  logic [NS:1]        vld;
  logic [NS:1]        en;

  rbi_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .time_step (time_step)
  );

  assign dts = $signed({1'b0, time_step});

  function automatic comp_t getc(input logic [62:0] f, input int unsigned i);
    logic [CB-1:0] raw;
    raw = f[i*CB +: CB];
    return COMP_MAX'($signed(raw));
  endfunction

  function automatic comp_t sat_c(input logic signed [63:0] x);
    if (x > CHI) return COMP_MAX'(CHI);
    if (x < CLO) return COMP_MAX'(CLO);
    return COMP_MAX'(x);
  endfunction

  function automatic logic clip(input logic signed [63:0] x);
    return (x > CHI) || (x < CLO);
  endfunction

  function automatic logic [62:0] pack3(input comp_t c0, input comp_t c1, input comp_t c2);
    return 63'({c2[CB-1:0], c1[CB-1:0], c0[CB-1:0]});
  endfunction

  // stage enables: load when empty or when the next stage moves on
  always_comb begin
    en[NS] = !vld[NS] || result_out.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign body_in.ready = en[1];

  always_comb begin
    logic [62:0]        rows [3];
    logic signed [63:0] acc;
    logic signed [63:0] rt [3][3];
    logic [59:0]        rem, res, tmp, bitv;
    logic [43:0]        dsh;
    logic [27:0]        mag;
    logic [15:0]        o;
    int                 g, kq;

    for (int k = 2; k <= NS; k++) begin
      nxt[k] = st[k-1];
    end
    nxt[1] = st[1];

    // stage 1: unpack, force times inverse mass, quaternion products
    rows[0] = body_in.inertia_row_zero;
    rows[1] = body_in.inertia_row_one;
    rows[2] = body_in.inertia_row_two;
    nxt[1].stat = (body_in.inverse_mass == 24'd0);
    nxt[1].flag = 1'b0;
    nxt[1].pin  = body_in.position;
    nxt[1].vin  = body_in.velocity;
    nxt[1].win  = body_in.angular_velocity;
    nxt[1].qin  = body_in.orientation;
    for (int i = 0; i < 3; i++) begin
      nxt[1].p[i]   = getc(body_in.position, i);
      nxt[1].v[i]   = getc(body_in.velocity, i);
      nxt[1].w[i]   = getc(body_in.angular_velocity, i);
      nxt[1].t[i]   = getc(body_in.torque_sum, i);
      nxt[1].fim[i] = getc(body_in.force_sum, i) * $signed({1'b0, body_in.inverse_mass});
      for (int j = 0; j < 3; j++) begin
        nxt[1].im_row[i][j] = getc(rows[i], j);
      end
    end
    for (int i = 0; i < 4; i++) begin
      nxt[1].q[i] = body_in.orientation[16*i +: 16];
    end
    nxt[1].qxx = nxt[1].q[1] * nxt[1].q[1];
    nxt[1].qyy = nxt[1].q[2] * nxt[1].q[2];
    nxt[1].qzz = nxt[1].q[3] * nxt[1].q[3];
    nxt[1].qxy = nxt[1].q[1] * nxt[1].q[2];
    nxt[1].qxz = nxt[1].q[1] * nxt[1].q[3];
    nxt[1].qyz = nxt[1].q[2] * nxt[1].q[3];
    nxt[1].qwx = nxt[1].q[0] * nxt[1].q[1];
    nxt[1].qwy = nxt[1].q[0] * nxt[1].q[2];
    nxt[1].qwz = nxt[1].q[0] * nxt[1].q[3];

    // stage 2: rotation matrix, force times dt in two halves
    rt[0][0] = (64'sd1 <<< 28) - 2 * (64'(st[1].qyy) + 64'(st[1].qzz));
    rt[0][1] = 2 * (64'(st[1].qxy) - 64'(st[1].qwz));
    rt[0][2] = 2 * (64'(st[1].qxz) + 64'(st[1].qwy));
    rt[1][0] = 2 * (64'(st[1].qxy) + 64'(st[1].qwz));
    rt[1][1] = (64'sd1 <<< 28) - 2 * (64'(st[1].qxx) + 64'(st[1].qzz));
    rt[1][2] = 2 * (64'(st[1].qyz) - 64'(st[1].qwx));
    rt[2][0] = 2 * (64'(st[1].qxz) - 64'(st[1].qwy));
    rt[2][1] = 2 * (64'(st[1].qyz) + 64'(st[1].qwx));
    rt[2][2] = (64'sd1 <<< 28) - 2 * (64'(st[1].qxx) + 64'(st[1].qyy));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nxt[2].r[i][j] = 20'(rnd(rt[i][j], 14));
      end
      nxt[2].fdlo[i] = $signed({1'b0, st[1].fim[i][22:0]}) * dts;
      nxt[2].fdhi[i] = $signed(st[1].fim[i][45:23]) * dts;
    end

    // stage 3: new velocity, R^T * torque products
    for (int i = 0; i < 3; i++) begin
      acc = 64'(st[2].v[i]) + rnd((64'(st[2].fdhi[i]) <<< 23) + 64'(st[2].fdlo[i]), 32);
      nxt[3].nv[i] = sat_c(acc);
      nxt[3].flag  = nxt[3].flag | clip(acc);
      for (int j = 0; j < 3; j++) begin
        nxt[3].at[i][j] = st[2].r[j][i] * st[2].t[j];
      end
    end

    // stage 4: body-frame torque, velocity times dt
    for (int i = 0; i < 3; i++) begin
      acc = 64'(st[3].at[i][0]) + 64'(st[3].at[i][1]) + 64'(st[3].at[i][2]);
      nxt[4].a[i]    = 27'(rnd(acc, 14));
      nxt[4].nvdt[i] = st[3].nv[i] * dts;
    end

    // stage 5: new position, inertia products
    for (int i = 0; i < 3; i++) begin
      acc = 64'(st[4].p[i]) + rnd(64'(st[4].nvdt[i]), 16);
      nxt[5].np[i] = sat_c(acc);
      nxt[5].flag  = nxt[5].flag | clip(acc);
      for (int j = 0; j < 3; j++) begin
        nxt[5].ia[i][j] = st[4].im_row[i][j] * st[4].a[j];
      end
    end

    // stage 6: body-frame angular acceleration
    for (int i = 0; i < 3; i++) begin
      acc = 64'(st[5].ia[i][0]) + 64'(st[5].ia[i][1]) + 64'(st[5].ia[i][2]);
      nxt[6].b[i] = 37'(rnd(acc, 12));
    end

    // stage 7: R * b, each product split on b
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nxt[7].rblo[i][j] = st[6].r[i][j] * $signed({1'b0, st[6].b[j][18:0]});
        nxt[7].rbhi[i][j] = st[6].r[i][j] * $signed(st[6].b[j][36:19]);
      end
    end

    // stage 8: world angular acceleration
    for (int i = 0; i < 3; i++) begin
      acc = 64'sd0;
      for (int j = 0; j < 3; j++) begin
        acc = acc + (64'(st[7].rbhi[i][j]) <<< 19) + 64'(st[7].rblo[i][j]);
      end
      nxt[8].c[i] = 42'(rnd(acc, 14));
    end

    // stage 9: acceleration times dt, split on c
    for (int i = 0; i < 3; i++) begin
      nxt[9].cdlo[i] = $signed({1'b0, st[8].c[i][20:0]}) * dts;
      nxt[9].cdhi[i] = $signed(st[8].c[i][41:21]) * dts;
    end

    // stage 10: new angular velocity
    for (int i = 0; i < 3; i++) begin
      acc = 64'(st[9].w[i]) + rnd((64'(st[9].cdhi[i]) <<< 21) + 64'(st[9].cdlo[i]), 16);
      nxt[10].nw[i] = sat_c(acc);
      nxt[10].flag  = nxt[10].flag | clip(acc);
    end

    // stage 11: (0,w') * q products
    nxt[11].dp[0][0] = st[10].nw[0] * st[10].q[1];
    nxt[11].dp[0][1] = st[10].nw[1] * st[10].q[2];
    nxt[11].dp[0][2] = st[10].nw[2] * st[10].q[3];
    nxt[11].dp[1][0] = st[10].nw[0] * st[10].q[0];
    nxt[11].dp[1][1] = st[10].nw[1] * st[10].q[3];
    nxt[11].dp[1][2] = st[10].nw[2] * st[10].q[2];
    nxt[11].dp[2][0] = st[10].nw[1] * st[10].q[0];
    nxt[11].dp[2][1] = st[10].nw[2] * st[10].q[1];
    nxt[11].dp[2][2] = st[10].nw[0] * st[10].q[3];
    nxt[11].dp[3][0] = st[10].nw[2] * st[10].q[0];
    nxt[11].dp[3][1] = st[10].nw[0] * st[10].q[2];
    nxt[11].dp[3][2] = st[10].nw[1] * st[10].q[1];

    // stage 12: quaternion derivative; scalar part is all negative terms
    nxt[12].d[0] = -(39'(st[11].dp[0][0]) + 39'(st[11].dp[0][1]) + 39'(st[11].dp[0][2]));
    for (int i = 1; i < 4; i++) begin
      nxt[12].d[i] = 39'(st[11].dp[i][0]) + 39'(st[11].dp[i][1]) - 39'(st[11].dp[i][2]);
    end

    // stage 13: derivative times dt, split on d
    for (int i = 0; i < 4; i++) begin
      nxt[13].ddlo[i] = $signed({1'b0, st[12].d[i][18:0]}) * dts;
      nxt[13].ddhi[i] = $signed(st[12].d[i][38:19]) * dts;
    end

    // stage 14: advanced quaternion, the half folded into the shift
    for (int i = 0; i < 4; i++) begin
      acc = 64'(st[13].q[i]) +
            rnd((64'(st[13].ddhi[i]) <<< 19) + 64'(st[13].ddlo[i]), 29);
      nxt[14].qn[i] = 28'(acc);
    end

    // stage 15: squares
    for (int i = 0; i < 4; i++) begin
      nxt[15].qsq[i] = 56'(st[14].qn[i] * st[14].qn[i]);
    end

    // stage 16: squared length
    nxt[16].nrem = 60'(st[15].qsq[0]) + 60'(st[15].qsq[1]) +
                   60'(st[15].qsq[2]) + 60'(st[15].qsq[3]);
    nxt[16].nres = '0;
    nxt[16].nz   = (nxt[16].nrem != '0);

    // stages 17..26: integer square root, three result bits per stage
    for (int s = 0; s < 10; s++) begin
      rem = st[16+s].nrem;
      res = st[16+s].nres;
      for (int j = 0; j < 3; j++) begin
        g    = 3 * s + j;
        bitv = 60'(1) << (58 - 2 * g);
        tmp  = res + bitv;
        if (rem >= tmp) begin
          rem = rem - tmp;
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
      end
      nxt[17+s].nrem = rem;
      nxt[17+s].nres = res;
    end

    // stage 27: divider operands, rounding folded into the dividend
    nxt[27].dd = {st[26].nres[28:0], 1'b0};
    for (int i = 0; i < 4; i++) begin
      mag = st[26].qn[i][27] ? 28'(-st[26].qn[i]) : 28'(st[26].qn[i]);
      nxt[27].neg[i] = st[26].qn[i][27];
      nxt[27].dr[i]  = {1'b0, mag, 15'd0} + 44'(st[26].nres[28:0]);
      nxt[27].quo[i] = '0;
    end

    // stages 28..32: restoring divide, three quotient bits per stage
    for (int s = 0; s < 5; s++) begin
      for (int j = 0; j < 3; j++) begin
        kq  = 14 - (3 * s + j);
        dsh = 44'(st[27+s].dd) << kq;
        for (int i = 0; i < 4; i++) begin
          if (j == 0) begin
            nxt[28+s].dr[i]  = st[27+s].dr[i];
            nxt[28+s].quo[i] = st[27+s].quo[i];
          end
          if (nxt[28+s].dr[i] >= dsh) begin
            nxt[28+s].dr[i]      = nxt[28+s].dr[i] - dsh;
            nxt[28+s].quo[i][kq] = 1'b1;
          end
        end
      end
    end

    // stage 33: sign, pack, static bypass; quotient never exceeds 2^14
    nxt[33].out_q = '0;
    for (int i = 0; i < 4; i++) begin
      o = st[32].neg[i] ? -{1'b0, st[32].quo[i]} : {1'b0, st[32].quo[i]};
      nxt[33].out_q[16*i +: 16] = o;
    end
    if (!st[32].nz) begin
      nxt[33].out_q = 64'd16384;
    end
    nxt[33].out_p = pack3(st[32].np[0], st[32].np[1], st[32].np[2]);
    nxt[33].out_v = pack3(st[32].nv[0], st[32].nv[1], st[32].nv[2]);
    nxt[33].out_w = pack3(st[32].nw[0], st[32].nw[1], st[32].nw[2]);
    if (st[32].stat) begin
      nxt[33].out_p = 63'(st[32].pin[3*CB-1:0]);
      nxt[33].out_v = 63'(st[32].vin[3*CB-1:0]);
      nxt[33].out_w = 63'(st[32].win[3*CB-1:0]);
      nxt[33].out_q = st[32].qin;
      nxt[33].flag  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= body_in.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign result_out.valid                = vld[NS];
  assign result_out.new_position         = st[NS].out_p;
  assign result_out.new_velocity         = st[NS].out_v;
  assign result_out.new_angular_velocity = st[NS].out_w;
  assign result_out.new_orientation      = st[NS].out_q;
  assign result_out.is_static            = st[NS].stat;
  assign result_out.saturated            = st[NS].flag;

`ifndef SYNTHESIS
  a_enter : assert property (@(posedge clk) disable iff (rst)
    body_in.valid && body_in.ready |=> vld[1])
    else $error("accepted item missing from first stage");

  a_static_clean : assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.is_static |-> !result_out.saturated)
    else $error("static body flagged as saturated");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    !en[1] |-> vld[1] && vld[NS] && !result_out.ready)
    else $error("input held off with room in the pipeline");
`endif

endmodule
`default_nettype wire

### hw/rtl/rbi_apb_regs.sv
`default_nettype none
module rbi_apb_regs
  import rbi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [15:0]       time_step
);

  logic [APB_AW-3:0] index;

  assign index  = paddr[APB_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
    end else if (psel && penable && pwrite && (index == REG_TIME_STEP)) begin
      time_step <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (index == REG_TIME_STEP) begin
      prdata = APB_DW'(time_step);
    end
  end

endmodule
`default_nettype wire

### verif/testbench.sv
`default_nettype none
module testbench;
  import rbi_pkg::*;

  localparam int CB         = 21;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 40;
  // one register slot past the last one; writes there must be ignored
  localparam logic [APB_AW-1:0] ADDR_TIME_STEP = APB_AW'(4 * REG_TIME_STEP);
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED  = APB_AW'(4 * (REG_TIME_STEP + 1));

  typedef struct {
    logic [62:0] position, velocity, angular_velocity, force_sum, torque_sum;
    logic [63:0] orientation;
    logic [23:0] inverse_mass;
    logic [62:0] inertia_row_zero, inertia_row_one, inertia_row_two;
  } body_t;

  typedef struct {
    logic [62:0] new_position, new_velocity, new_angular_velocity;
    logic [63:0] new_orientation;
    logic        is_static, saturated;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rbi_body_if   body ();
  rbi_result_if res ();

  rigid_body_integrator #(.COMPONENT_BITS(CB)) i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .body_in(body), .result_out(res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [15:0] dt_model = TIME_STEP_RESET;
  step_t expected_steps[$];
  int errors = 0, bodies_sent = 0, results_seen = 0, static_seen = 0, sat_seen = 0;
  int burst_left = 0, gap_max = 4, stall_pct = 30, idle_cycles = 0;

  initial begin
    body.valid = 1'b0;
    body.position = '0; body.velocity = '0; body.angular_velocity = '0;
    body.force_sum = '0; body.torque_sum = '0; body.orientation = '0;
    body.inverse_mass = '0; body.inertia_row_zero = '0;
    body.inertia_row_one = '0; body.inertia_row_two = '0;
    res.ready = 1'b1;
  end

  // ---------------- predictor ----------------
  function automatic longint comp(logic [62:0] v, int i);
    logic [CB-1:0] r;
    r = v[i*CB +: CB];
    return longint'($signed(r));
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi, inout bit f);
    if (v < lo) begin
      f = 1'b1;
      return lo;
    end
    if (v > hi) begin
      f = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic longint clip_comp(longint v, inout bit f);
    return clip(v, -(64'sd1 <<< (CB - 1)), (64'sd1 <<< (CB - 1)) - 1, f);
  endfunction

  function automatic logic [62:0] pack3(longint c[3]);
    logic [62:0] r;
    r = '0;
    for (int i = 0; i < 3; i++) r[i*CB +: CB] = c[i][CB-1:0];
    return r;
  endfunction

  function automatic longint floor_sqrt(bit [63:0] n);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint div_nearest(longint a, longint l);
    longint m;
    m = (a < 0) ? -a : a;
    m = (m * 2 + l) / (2 * l);
    return (a < 0) ? -m : m;
  endfunction

  function automatic step_t integrate(body_t b, logic [15:0] dt_reg);
    longint p[3], v[3], w[3], f[3], t[3], q[4], im[3][3], rot[3][3];
    longint a[3], bb[3], c[3], np[3], nv[3], nw[3], d[4], qn[4];
    longint dt, m, len, o;
    bit [63:0] n2;
    bit flag;
    step_t r;
    dt = longint'(dt_reg);
    m = longint'(b.inverse_mass);
    flag = 1'b0;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = comp(b.position, i); v[i] = comp(b.velocity, i);
      w[i] = comp(b.angular_velocity, i); f[i] = comp(b.force_sum, i);
      t[i] = comp(b.torque_sum, i);
      im[0][i] = comp(b.inertia_row_zero, i);
      im[1][i] = comp(b.inertia_row_one, i);
      im[2][i] = comp(b.inertia_row_two, i);
    end
    for (int i = 0; i < 4; i++) q[i] = longint'($signed(b.orientation[i*16 +: 16]));
    if (m == 0) begin
      r.new_position = pack3(p); r.new_velocity = pack3(v);
      r.new_angular_velocity = pack3(w); r.new_orientation = b.orientation;
      r.is_static = 1'b1; r.saturated = 1'b0;
      return r;
    end
    for (int i = 0; i < 3; i++) nv[i] = clip_comp(v[i] + round_half_up(f[i] * m * dt, 32), flag);
    for (int i = 0; i < 3; i++) np[i] = clip_comp(p[i] + round_half_up(nv[i] * dt, 16), flag);
    rot[0][0] = (64'sd1 <<< 28) - 2 * (q[2] * q[2] + q[3] * q[3]);
    rot[0][1] = 2 * (q[1] * q[2] - q[0] * q[3]);
    rot[0][2] = 2 * (q[1] * q[3] + q[0] * q[2]);
    rot[1][0] = 2 * (q[1] * q[2] + q[0] * q[3]);
    rot[1][1] = (64'sd1 <<< 28) - 2 * (q[1] * q[1] + q[3] * q[3]);
    rot[1][2] = 2 * (q[2] * q[3] - q[0] * q[1]);
    rot[2][0] = 2 * (q[1] * q[3] - q[0] * q[2]);
    rot[2][1] = 2 * (q[2] * q[3] + q[0] * q[1]);
    rot[2][2] = (64'sd1 <<< 28) - 2 * (q[1] * q[1] + q[2] * q[2]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) rot[i][j] = round_half_up(rot[i][j], 14);
    for (int i = 0; i < 3; i++)
      a[i] = round_half_up(rot[0][i] * t[0] + rot[1][i] * t[1] + rot[2][i] * t[2], 14);
    for (int i = 0; i < 3; i++)
      bb[i] = round_half_up(im[i][0] * a[0] + im[i][1] * a[1] + im[i][2] * a[2], 12);
    for (int i = 0; i < 3; i++)
      c[i] = round_half_up(rot[i][0] * bb[0] + rot[i][1] * bb[1] + rot[i][2] * bb[2], 14);
    for (int i = 0; i < 3; i++) nw[i] = clip_comp(w[i] + round_half_up(c[i] * dt, 16), flag);
    d[0] = -nw[0] * q[1] - nw[1] * q[2] - nw[2] * q[3];
    d[1] = nw[0] * q[0] + nw[1] * q[3] - nw[2] * q[2];
    d[2] = nw[1] * q[0] + nw[2] * q[1] - nw[0] * q[3];
    d[3] = nw[2] * q[0] + nw[0] * q[2] - nw[1] * q[1];
    for (int i = 0; i < 4; i++) begin
      qn[i] = q[i] + round_half_up(d[i] * dt, 29);
      n2 += 64'(qn[i] * qn[i]);
    end
    r.new_orientation = '0;
    if (n2 == 0) begin
      r.new_orientation[15:0] = 16'd16384;
    end else begin
      len = floor_sqrt(n2);
      for (int i = 0; i < 4; i++) begin
        o = clip(div_nearest(qn[i] * 16384, len), -32768, 32767, flag);
        r.new_orientation[i*16 +: 16] = o[15:0];
      end
    end
    r.new_position = pack3(np); r.new_velocity = pack3(nv);
    r.new_angular_velocity = pack3(nw);
    r.is_static = 1'b0; r.saturated = flag;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [62:0] vec3(longint x, longint y, longint z);
    longint c[3];
    c[0] = x; c[1] = y; c[2] = z;
    return pack3(c);
  endfunction

  function automatic logic [62:0] rand_vec(int span);
    if (span == 0) return 63'({$urandom, $urandom} >> 1);
    return vec3(longint'($urandom_range(0, 2 * span)) - span,
                longint'($urandom_range(0, 2 * span)) - span,
                longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [63:0] quat(int w, int x, int y, int z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  function automatic logic [63:0] rand_quat();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return quat(16384, 0, 0, 0);
      2: return quat(11585, 0, -11585, 0);
      3: return quat(8192, 8192, 8192, 8192);
      4: return '0;
      default: return quat($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                           $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384);
    endcase
  endfunction

  function automatic body_t rand_body();
    body_t b;
    int span;
    // mostly plausible magnitudes, some full-range noise
    span = ($urandom_range(0, 4) == 0) ? 0 : (1 << $urandom_range(8, 16));
    b.position = rand_vec(span); b.velocity = rand_vec(span);
    b.angular_velocity = rand_vec(span); b.force_sum = rand_vec(span);
    b.torque_sum = rand_vec(span); b.orientation = rand_quat();
    case ($urandom_range(0, 9))
      0: b.inverse_mass = '0;
      1: b.inverse_mass = 24'hffffff;
      2: b.inverse_mass = 24'($urandom);
      default: b.inverse_mass = 24'($urandom_range(1, 24'h3ffff));
    endcase
    b.inertia_row_zero = rand_vec(span); b.inertia_row_one = rand_vec(span);
    b.inertia_row_two = rand_vec(span);
    return b;
  endfunction

  function automatic body_t uniform_body(logic [62:0] v3, logic [63:0] q, logic [23:0] m);
    body_t b;
    b.position = v3; b.velocity = v3; b.angular_velocity = v3; b.force_sum = v3;
    b.torque_sum = v3; b.orientation = q; b.inverse_mass = m;
    b.inertia_row_zero = v3; b.inertia_row_one = v3; b.inertia_row_two = v3;
    return b;
  endfunction

  task automatic send_body(body_t b);
    bit ok;
    int gap;
    body.valid <= 1'b1;
    body.position <= b.position; body.velocity <= b.velocity;
    body.angular_velocity <= b.angular_velocity; body.force_sum <= b.force_sum;
    body.torque_sum <= b.torque_sum; body.orientation <= b.orientation;
    body.inverse_mass <= b.inverse_mass; body.inertia_row_zero <= b.inertia_row_zero;
    body.inertia_row_one <= b.inertia_row_one; body.inertia_row_two <= b.inertia_row_two;
    do begin
      @(negedge clk);
      ok = body.ready;
      @(posedge clk);
    end while (!ok);
    expected_steps.insert(expected_steps.size(), integrate(b, dt_model));
    bodies_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        body.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    body.valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    bit ok;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ok = pready;
      @(posedge clk);
    end while (!ok);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_TIME_STEP) dt_model = data[15:0];
  endtask

  task automatic set_time_step(logic [15:0] dt);
    settle();
    apb_write(ADDR_TIME_STEP, {16'h0, dt});
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    longint mx, mn;
    mx = (64'sd1 <<< (CB - 1)) - 1;
    mn = -(64'sd1 <<< (CB - 1));
    // default time step from reset
    send_body(uniform_body(vec3(4096, -4096, 100), quat(16384, 0, 0, 0), 24'h010000));
    // static bodies: full-range payload passes unchanged
    send_body(uniform_body({63{1'b1}}, 64'hffff_ffff_ffff_ffff, '0));
    send_body(uniform_body(vec3(mx, mn, 0), quat(-32768, 32767, 0, 1), '0));
    // extremes saturate
    send_body(uniform_body(vec3(mx, mx, mx), quat(32767, 32767, 32767, 32767), 24'hffffff));
    send_body(uniform_body(vec3(mn, mn, mn), quat(-32768, -32768, -32768, -32768),
                           24'hffffff));
    send_body(uniform_body(vec3(mx, mn, mx), quat(16384, 0, 0, 0), 24'h000001));
    // zero-length quaternion gives identity
    send_body(uniform_body(vec3(4096, 4096, 4096), '0, 24'h008000));
    send_body(uniform_body('0, '0, 24'h000001));
    // unnormalised quaternions used as given
    send_body(uniform_body(vec3(2048, -1024, 512), quat(100, 0, 0, 0), 24'h010000));
    send_body(uniform_body(vec3(2048, -1024, 512), quat(4, -3, 2, 1), 24'h020000));
    send_body(uniform_body(vec3(-300, 700, 4095), quat(11585, 11585, 0, 0), 24'h004000));
    send_body(uniform_body(vec3(-1, -1, -1), quat(-16384, 0, 0, 0), 24'h7fffff));
    set_time_step(16'hffff);
    send_body(uniform_body(vec3(mx, mx, mx), quat(16384, 0, 0, 0), 24'hffffff));
    send_body(uniform_body(vec3(1000, -2000, 3000), quat(0, 0, 16384, 0), 24'h010000));
    set_time_step(16'h0000);
    send_body(uniform_body(vec3(mx, mn, mx), quat(8192, 8192, 8192, 8192), 24'hffffff));
    send_body(uniform_body(vec3(1000, -2000, 3000), quat(5, 6, 7, 8), 24'h010000));
    // an unmapped register write changes nothing
    settle();
    apb_write(ADDR_UNMAPPED, 32'h0000_1234);
    send_body(uniform_body(vec3(1000, -2000, 3000), quat(0, 16384, 0, 0), 24'h010000));
  endtask

  task automatic random_phase(int n, int gmax, int stall);
    gap_max = gmax;
    stall_pct = stall;
    repeat (n) send_body(rand_body());
  endtask

  task automatic test_time_steps();
    logic [15:0] steps[5];
    steps = '{16'd1, TIME_STEP_RESET, 16'd32768, 16'hffff, 16'h0000};
    foreach (steps[i]) begin
      set_time_step(steps[i]);
      random_phase(50, $urandom_range(0, 6), $urandom_range(0, 60));
    end
  endtask

  task automatic test_random();
    for (int k = 0; k < 9; k++) begin
      set_time_step(16'($urandom));
      // every third phase runs flat out on both sides
      if (k % 3 == 0) random_phase(100, 0, 0);
      else random_phase(100, $urandom_range(1, 10), $urandom_range(10, 80));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_time_steps();
    test_random();
    settle();
    $display("%0d bodies stepped, %0d results (%0d static, %0d saturated) checked",
             bodies_sent, results_seen, static_seen, sat_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side stalls in runs of random length
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      res.ready <= 1'b0;
      stall_run <= $urandom_range(0, 7);
    end else begin
      res.ready <= 1'b1;
      stall_run <= $urandom_range(0, 5);
    end
  end

  // check results and watch for a hang
  always @(negedge clk) begin
    step_t e;
    if (res.valid && res.ready) begin
      results_seen++;
      if (expected_steps.size() == 0) begin
        $error("result with no body outstanding");
        errors++;
      end else begin
        e = expected_steps.pop_front();
        if (res.is_static) static_seen++;
        if (res.saturated) sat_seen++;
        if (res.new_position !== e.new_position) begin
          $error("new_position: expected %h, got %h", e.new_position, res.new_position);
          errors++;
        end
        if (res.new_velocity !== e.new_velocity) begin
          $error("new_velocity: expected %h, got %h", e.new_velocity, res.new_velocity);
          errors++;
        end
        if (res.new_angular_velocity !== e.new_angular_velocity) begin
          $error("new_angular_velocity: expected %h, got %h", e.new_angular_velocity,
                 res.new_angular_velocity);
          errors++;
        end
        if (res.new_orientation !== e.new_orientation) begin
          $error("new_orientation: expected %h, got %h", e.new_orientation,
                 res.new_orientation);
          errors++;
        end
        if (res.is_static !== e.is_static) begin
          $error("is_static: expected %b, got %b", e.is_static, res.is_static);
          errors++;
        end
        if (res.saturated !== e.saturated) begin
          $error("saturated: expected %b, got %b", e.saturated, res.saturated);
          errors++;
        end
      end
    end
    if ((res.valid && res.ready) || (body.valid && body.ready) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
